// File: hdl/xmr_pkg.sv
`default_nettype none
package xmr_pkg;
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_C   = 8'h43;

   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_NEXT  = 3'd1;
   localparam logic [2:0] ACT_BYTE  = 3'd2;
   localparam logic [2:0] ACT_TMO   = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [2:0] ST_BUSY   = 3'd0;
   localparam logic [2:0] ST_NOPKT  = 3'd1;
   localparam logic [2:0] ST_GOOD   = 3'd2;
   localparam logic [2:0] ST_END    = 3'd3;
   localparam logic [2:0] ST_CANCEL = 3'd4;
   localparam logic [2:0] ST_ABORT  = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HDR, PH_HDR_C, PH_RECV, PH_CAN2
   } phase_type;

   // one queued item handed from the front to the back end
   typedef struct packed {
      logic [2:0] ntx;
      logic [7:0] tx0;
      logic [2:0] status;
      logic [10:0] len;
      logic [7:0] data;
   } cmd_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] v;
      v = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
      end
      return v;
   endfunction
endpackage
`default_nettype wire

// File: hdl/xmodem_receiver_unit.sv
// XMODEM / XMODEM-1K receiver, one event per item.
// Items pass a pending register, then a two-entry queue; payload read
//   data comes from a registered 1024x8 payload memory port.
// One item per cycle unless stalled; each yields 1 to 4 result items, one per cycle.
// Reset: synchronous, active high; clears control state, max_retries back to 10.
`default_nettype none
module xmodem_receiver_unit
   import xmr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [9:0]  req_read_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic [2:0]       rsp_status,
   output logic [10:0]      rsp_payload_len,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_last
);
   // front end: protocol state, frame checks, payload memory
   cmd_type cmd;
   logic cmd_valid, cmd_ready;

   xmr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(req_valid), .in_ready(req_ready),
      .action(req_action), .rx_byte(req_rx_byte), .read_index(req_read_index),
      .cmd_valid, .cmd_ready, .cmd
   );

   // back end: queue plus expansion into reply bytes
   xmr_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid, .rsp_ready, .rsp_tx_valid, .rsp_tx_byte, .rsp_status,
      .rsp_payload_len, .rsp_read_data, .rsp_last
   );
endmodule
`default_nettype wire

// File: hdl/xmr_front.sv
`default_nettype none
module xmr_front
   import xmr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [2:0]  action,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [9:0]  read_index,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);
   localparam int AW = $clog2(MAX_PAYLOAD);

   logic [7:0] mem [MAX_PAYLOAD];
   logic [7:0] max_ff, fcmd_ff, fnum_ff, finv_ff, sum_ff, lastn_ff, reply_ff, retr_ff;
   logic [15:0] rchk_ff, crc_ff;
   logic [10:0] cnt_ff;
   logic crcm_ff, pv_ff;
   phase_type ph_ff;

   // pending result: registered with read data from memory
   logic pend_ff;
   cmd_type pc_ff;
   logic rd_en_ff;
   logic [7:0] rd_q_ff;

   logic [7:0] fcmd_in, fnum_in, finv_in, sum_in, lastn_in, reply_in, retr_in;
   logic [15:0] rchk_in, crc_in;
   logic [10:0] cnt_in;
   logic crcm_in, pv_in;
   phase_type ph_in;
   cmd_type c_in;
   logic wr_en, rd_en;
   logic [AW-1:0] wr_addr;

   logic acc;
   assign in_ready = !pend_ff || cmd_ready;
   assign acc = in_valid && in_ready;
   assign cmd_valid = pend_ff;
   always_comb begin
      cmd = pc_ff;
      if (rd_en_ff) cmd.data = rd_q_ff;
   end

   function automatic logic [10:0] flen(input logic [7:0] fc);
      return (fc == CH_STX) ? 11'(MAX_PAYLOAD) : 11'd128;
   endfunction

   always_comb begin
      logic [10:0] len, total, pos;
      logic ok;
      logic [7:0] rdec;
      fcmd_in = fcmd_ff; fnum_in = fnum_ff; finv_in = finv_ff; sum_in = sum_ff;
      lastn_in = lastn_ff; reply_in = reply_ff; retr_in = retr_ff;
      rchk_in = rchk_ff; crc_in = crc_ff; cnt_in = cnt_ff;
      crcm_in = crcm_ff; pv_in = pv_ff; ph_in = ph_ff;
      c_in = '0;
      wr_en = 1'b0; wr_addr = '0; rd_en = 1'b0;
      rdec = (retr_ff != 8'd0) ? retr_ff - 8'd1 : 8'd0;
      len = flen(fcmd_ff);
      pos = cnt_ff;
      total = 11'd3 + len + {10'd0, crcm_ff};
      ok = 1'b0;
      unique case (action)
         ACT_START: begin
            retr_in = max_ff; lastn_in = '0; reply_in = CH_C;
            crcm_in = 1'b0; pv_in = 1'b0; ph_in = PH_IDLE;
         end
         ACT_NEXT: begin
            c_in.tx0 = reply_ff;
            c_in.ntx = (reply_ff != 8'd0) ? 3'd1 : 3'd0;
            if (retr_ff < (max_ff >> 1)) reply_in = CH_NAK;
            if (retr_ff != 8'd0) begin
               pv_in = 1'b0;
               ph_in = (reply_ff == CH_C) ? PH_HDR_C : PH_HDR;
            end else begin
               c_in.ntx = c_in.ntx + 3'd3;
               reply_in = 8'd0; ph_in = PH_IDLE; c_in.status = ST_ABORT;
            end
         end
         ACT_BYTE: begin
            priority case (ph_ff)
               PH_HDR, PH_HDR_C: begin
                  if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
                     if (ph_ff == PH_HDR_C) crcm_in = 1'b1;
                     if (retr_ff > 8'd2) retr_in = 8'd2;
                     fcmd_in = rx_byte; cnt_in = '0; crc_in = '0; sum_in = '0;
                     rchk_in = '0; ph_in = PH_RECV;
                  end else if (rx_byte == CH_EOT) begin
                     retr_in = 8'd1; c_in.ntx = 3'd1; c_in.tx0 = CH_ACK;
                     ph_in = PH_IDLE; c_in.status = ST_END;
                  end else if (rx_byte == CH_CAN) begin
                     ph_in = PH_CAN2;
                  end else begin
                     retr_in = rdec; ph_in = PH_IDLE; c_in.status = ST_NOPKT;
                  end
               end
               PH_CAN2: begin
                  if (rx_byte == CH_CAN) begin
                     retr_in = 8'd1; c_in.ntx = 3'd1; c_in.tx0 = CH_ACK;
                     ph_in = PH_IDLE; c_in.status = ST_CANCEL;
                  end else begin
                     retr_in = rdec; ph_in = PH_IDLE; c_in.status = ST_NOPKT;
                  end
               end
               PH_RECV: begin
                  if (pos == 11'd0) fnum_in = rx_byte;
                  else if (pos == 11'd1) finv_in = rx_byte;
                  else if (pos < 11'd2 + len) begin
                     wr_en = 1'b1;
                     wr_addr = AW'(pos - 11'd2);
                     crc_in = crc_byte(crc_ff, rx_byte);
                     sum_in = sum_ff + rx_byte;
                  end else rchk_in = {rchk_ff[7:0], rx_byte};
                  cnt_in = pos + 11'd1;
                  if (cnt_in >= total) begin
                     ok = ((fnum_in ^ finv_in) == 8'hFF) &&
                          (fnum_in == lastn_ff || fnum_in == lastn_ff + 8'd1) &&
                          (crcm_ff ? (rchk_in == crc_in) : (rchk_in[7:0] == sum_in));
                     if (ok) begin
                        lastn_in = fnum_in; pv_in = 1'b1; retr_in = 8'd1;
                        reply_in = CH_ACK; c_in.status = ST_GOOD;
                     end else begin
                        fcmd_in = '0; retr_in = rdec; c_in.status = ST_NOPKT;
                     end
                     ph_in = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         ACT_TMO: begin
            if (ph_ff == PH_RECV) fcmd_in = '0;
            if (ph_ff != PH_IDLE) begin
               retr_in = rdec; ph_in = PH_IDLE; c_in.status = ST_NOPKT;
            end
         end
         default: ;
      endcase
      c_in.len = pv_in ? flen(fcmd_in) : 11'd0;
      if (action == ACT_READ && pv_ff && {1'b0, read_index} < c_in.len) rd_en = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (acc && wr_en) mem[wr_addr] <= rx_byte;
      if (acc && rd_en) rd_q_ff <= mem[AW'(read_index)];
      if (acc) pc_ff <= c_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 8'd10; fcmd_ff <= '0; fnum_ff <= '0; finv_ff <= '0; sum_ff <= '0;
         lastn_ff <= '0; reply_ff <= CH_C; retr_ff <= 8'd10; rchk_ff <= '0; crc_ff <= '0;
         cnt_ff <= '0; crcm_ff <= 1'b0; pv_ff <= 1'b0; ph_ff <= PH_IDLE;
         pend_ff <= 1'b0; rd_en_ff <= 1'b0;
      end else begin
         if (csr_we) max_ff <= csr_wdata;
         if (acc) begin
            fcmd_ff <= fcmd_in; fnum_ff <= fnum_in; finv_ff <= finv_in; sum_ff <= sum_in;
            lastn_ff <= lastn_in; reply_ff <= reply_in; retr_ff <= retr_in;
            rchk_ff <= rchk_in; crc_ff <= crc_in; cnt_ff <= cnt_in;
            crcm_ff <= crcm_in; pv_ff <= pv_in; ph_ff <= ph_in;
            rd_en_ff <= rd_en;
         end
         if (acc) pend_ff <= 1'b1;
         else if (cmd_ready) pend_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// File: hdl/xmr_back.sv
`default_nettype none
module xmr_back
   import xmr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         cmd_valid,
   output logic              cmd_ready,
   input  wire cmd_type      cmd,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_tx_valid,
   output logic [7:0]        rsp_tx_byte,
   output logic [2:0]        rsp_status,
   output logic [10:0]       rsp_payload_len,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_last
);
   // two-entry queue of commands, then expansion into result beats
   cmd_type q_ff [2];
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic [2:0] beat_ff, beat_in;
   cmd_type h;
   logic [2:0] n;
   logic pop, push;

   assign h = q_ff[rd_ff];
   assign n = (h.ntx == 3'd0) ? 3'd1 : h.ntx;
   assign rsp_valid = cnt_ff != 2'd0;
   assign cmd_ready = cnt_ff != 2'd2;
   assign push = cmd_valid && cmd_ready;
   assign rsp_tx_valid = h.ntx != 3'd0;
   assign rsp_tx_byte = (h.ntx == 3'd0) ? 8'd0 :
                        (beat_ff == 3'd0 && h.tx0 != CH_CAN && h.ntx != 3'd3) ? h.tx0 :
                        (beat_ff == 3'd0 && h.ntx == 3'd1) ? h.tx0 :
                        (beat_ff == 3'd0 && h.ntx == 3'd4) ? h.tx0 : CH_CAN;
   assign rsp_status = h.status;
   assign rsp_payload_len = h.len;
   assign rsp_read_data = h.data;
   assign rsp_last = beat_ff == n - 3'd1;
   assign pop = rsp_valid && rsp_ready && rsp_last;
   always_comb begin
      beat_in = beat_ff;
      if (rsp_valid && rsp_ready) beat_in = rsp_last ? 3'd0 : beat_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cmd;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0; beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// File: hdl/xmr_checker.sv
`default_nettype none
module xmr_props
   import xmr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_tx_valid,
   input wire logic [7:0]  rsp_tx_byte,
   input wire logic [2:0]  rsp_status,
   input wire logic        rsp_last
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("result changed under stall");
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'd0 && rsp_last)
      else $error("idle result not single");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_ABORT)
      else $error("bad status");
   a_abort_can: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_ABORT && rsp_last |-> rsp_tx_byte == CH_CAN)
      else $error("abort not ended by CAN");
endmodule

bind xmodem_receiver_unit xmr_props u_props (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_tx_valid, .rsp_tx_byte,
   .rsp_status, .rsp_last
);
`default_nettype wire

// File: bench/xmr_checker.sv
`default_nettype none
module xmr_checker
   import xmr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [9:0]  req_read_index,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic        rsp_tx_valid,
   input  wire logic [7:0]  rsp_tx_byte,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [10:0] rsp_payload_len,
   input  wire logic [7:0]  rsp_read_data,
   input  wire logic        rsp_last,
   input  wire logic        at_end,
   output int               fail_count
);
   localparam int BIG_LEN = 1024;

   typedef struct {
      logic        txv;
      logic [7:0]  txb;
      logic [2:0]  st;
      logic [10:0] len;
      logic [7:0]  data;
      logic        last;
   } rsp_item_t;

   rsp_item_t   due_q[$];
   logic [7:0]  payload_mem[BIG_LEN];
   logic [7:0]  cmd_byte, num_byte, inv_byte;
   logic [15:0] got_check, crc_run;
   logic [10:0] rx_count;
   logic [7:0]  sum_run, last_num, reply, retries, max_retries;
   bit          crc_on, pkt_ok, tail_flagged;
   phase_type   ph;

   // bitwise CRC-16/XMODEM, MSB first; also used by the stimulus side
   function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ d[i];
         c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
      end
      return c;
   endfunction

   function automatic logic [10:0] frame_len();
      return (cmd_byte == CH_STX) ? 11'(BIG_LEN) : 11'd128;
   endfunction

   task automatic drop_try();
      if (retries != 0) retries--;
      ph = PH_IDLE;
   endtask

   task automatic predict(input logic [2:0] act, input logic [7:0] b, input logic [9:0] ix);
      logic [7:0]  tx[4];
      int          ntx;
      logic [2:0]  st;
      logic [7:0]  data, sent;
      logic [10:0] len;
      int          total, pos, n;
      bit          good;
      rsp_item_t   r;
      ntx = 0;
      st = ST_BUSY;
      data = 8'h00;
      case (act)
         ACT_START: begin
            retries = max_retries;
            last_num = 8'h00;
            reply = CH_C;
            crc_on = 0;
            pkt_ok = 0;
            ph = PH_IDLE;
         end
         ACT_NEXT: begin
            sent = reply;
            if (sent != 8'h00) begin
               tx[ntx] = sent;
               ntx++;
            end
            if (retries < (max_retries >> 1)) reply = CH_NAK;
            if (retries != 0) begin
               pkt_ok = 0;
               ph = (sent == CH_C) ? PH_HDR_C : PH_HDR;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  tx[ntx] = CH_CAN;
                  ntx++;
               end
               reply = 8'h00;
               ph = PH_IDLE;
               st = ST_ABORT;
            end
         end
         ACT_BYTE: begin
            if (ph == PH_HDR || ph == PH_HDR_C) begin
               if (b == CH_SOH || b == CH_STX) begin
                  if (ph == PH_HDR_C) crc_on = 1;
                  if (retries > 8'd2) retries = 8'd2;
                  cmd_byte = b;
                  rx_count = '0;
                  crc_run = '0;
                  sum_run = '0;
                  got_check = '0;
                  ph = PH_RECV;
               end else if (b == CH_EOT) begin
                  retries = 8'd1;
                  tx[ntx] = CH_ACK;
                  ntx++;
                  ph = PH_IDLE;
                  st = ST_END;
               end else if (b == CH_CAN) begin
                  ph = PH_CAN2;
               end else begin
                  drop_try();
                  st = ST_NOPKT;
               end
            end else if (ph == PH_CAN2) begin
               if (b == CH_CAN) begin
                  retries = 8'd1;
                  tx[ntx] = CH_ACK;
                  ntx++;
                  ph = PH_IDLE;
                  st = ST_CANCEL;
               end else begin
                  drop_try();
                  st = ST_NOPKT;
               end
            end else if (ph == PH_RECV) begin
               pos = rx_count;
               if (pos == 0) num_byte = b;
               else if (pos == 1) inv_byte = b;
               else if (pos < 2 + frame_len()) begin
                  payload_mem[pos - 2] = b;
                  crc_run = crc_next(crc_run, b);
                  sum_run = sum_run + b;
               end else begin
                  got_check = {got_check[7:0], b};
               end
               rx_count = rx_count + 11'd1;
               total = 3 + frame_len() + (crc_on ? 1 : 0);
               if (rx_count >= total) begin
                  good = ((num_byte ^ inv_byte) == 8'hFF) &&
                         (num_byte == last_num || num_byte == 8'(last_num + 8'd1)) &&
                         (crc_on ? (got_check == crc_run) : (got_check[7:0] == sum_run));
                  if (good) begin
                     last_num = num_byte;
                     pkt_ok = 1;
                     retries = 8'd2;
                     reply = CH_ACK;
                     st = ST_GOOD;
                  end else begin
                     cmd_byte = 8'h00;
                     st = ST_NOPKT;
                  end
                  drop_try();
               end
            end
         end
         ACT_TMO: begin
            if (ph == PH_RECV) cmd_byte = 8'h00;
            if (ph != PH_IDLE) begin
               drop_try();
               st = ST_NOPKT;
            end
         end
         default: ;
      endcase
      len = pkt_ok ? frame_len() : 11'd0;
      if (act == ACT_READ && pkt_ok && 11'(ix) < len) data = payload_mem[ix];
      n = (ntx > 0) ? ntx : 1;
      for (int k = 0; k < n; k++) begin
         r.txv = (ntx > 0);
         r.txb = (ntx > 0) ? tx[k] : 8'h00;
         r.st = st;
         r.len = len;
         r.data = data;
         r.last = (k == n - 1);
         due_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_t e;
      if (reset) begin
         due_q.delete();
         cmd_byte = '0; num_byte = '0; inv_byte = '0;
         got_check = '0; crc_run = '0; rx_count = '0; sum_run = '0;
         last_num = '0; reply = CH_C; max_retries = 8'd10; retries = 8'd10;
         crc_on = 0; pkt_ok = 0; ph = PH_IDLE;
         fail_count = 0;
         tail_flagged = 0;
      end else begin
         if (csr_we) max_retries = csr_wdata;
         if (req_valid && req_ready) predict(req_action, req_rx_byte, req_read_index);
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               $error("unexpected result item, tx_byte %0h status %0d", rsp_tx_byte, rsp_status);
               fail_count++;
            end else begin
               e = due_q.pop_front();
               if (rsp_tx_valid !== e.txv) begin
                  $error("tx_valid: expected %0h, got %0h", e.txv, rsp_tx_valid);
                  fail_count++;
               end
               if (rsp_tx_byte !== e.txb) begin
                  $error("tx_byte: expected %0h, got %0h", e.txb, rsp_tx_byte);
                  fail_count++;
               end
               if (rsp_status !== e.st) begin
                  $error("status: expected %0h, got %0h", e.st, rsp_status);
                  fail_count++;
               end
               if (rsp_payload_len !== e.len) begin
                  $error("payload_len: expected %0h, got %0h", e.len, rsp_payload_len);
                  fail_count++;
               end
               if (rsp_read_data !== e.data) begin
                  $error("read_data: expected %0h, got %0h", e.data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0h, got %0h", e.last, rsp_last);
                  fail_count++;
               end
            end
         end
         if (at_end && due_q.size() != 0 && !tail_flagged) begin
            $error("%0d result items never arrived", due_q.size());
            fail_count++;
            tail_flagged = 1;
         end
      end
   end
endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
   import xmr_pkg::*;

   // ways to spoil a frame
   localparam int FLAW_NONE  = 0;
   localparam int FLAW_INV   = 1;  // number complement wrong
   localparam int FLAW_CHECK = 2;  // CRC / sum wrong
   localparam int FLAW_NUM   = 3;  // packet number out of sequence
   localparam int FLAW_SHORT = 4;  // frame cut off by a timeout
   localparam int HOLD_CYCLES = 80;

   logic        clock, reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_valid, req_ready;
   logic [2:0]  req_action;
   logic [7:0]  req_rx_byte;
   logic [9:0]  req_read_index;
   logic        rsp_valid, rsp_ready;
   logic        rsp_tx_valid, rsp_last;
   logic [7:0]  rsp_tx_byte, rsp_read_data;
   logic [2:0]  rsp_status;
   logic [10:0] rsp_payload_len;
   logic        at_end;
   int          fail_count;

   int          sent_cnt, done_cnt;  // items accepted / items whose last result came
   bit          gaps_on, stalls_on, hold_req, held;
   logic [7:0]  cur_max;             // max_retries as last written

   xmodem_receiver_unit DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_rx_byte(req_rx_byte),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_tx_valid(rsp_tx_valid), .rsp_tx_byte(rsp_tx_byte),
      .rsp_status(rsp_status), .rsp_payload_len(rsp_payload_len),
      .rsp_read_data(rsp_read_data), .rsp_last(rsp_last)
   );

   xmr_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20000000;
      $display("tb_top: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) done_cnt <= 0;
      else if (rsp_valid && rsp_ready && rsp_last) done_cnt <= done_cnt + 1;
   end

   // receiver side: random stall bursts, plus one long hold on request
   initial begin
      rsp_ready = 1;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            rsp_ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1;
            rsp_ready = 1;
         end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            rsp_ready = 0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ready = 1;
         end
      end
   end

   // one item; an optional idle burst first, then hold valid until taken
   task automatic send_item(input logic [2:0] act, input logic [7:0] b, input logic [9:0] ix);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid = 1;
      req_action = act;
      req_rx_byte = b;
      req_read_index = ix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_cnt++;
   endtask

   task automatic rx(input logic [7:0] b);
      send_item(ACT_BYTE, b, 10'($urandom));
   endtask

   task automatic event_only(input logic [2:0] act);
      send_item(act, 8'($urandom), 10'($urandom));
   endtask

   // every item answered, then an idle wait for anything still in flight
   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (done_cnt != sent_cnt) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_max_retries(input logic [7:0] v);
      drain();
      @(negedge clock);
      csr_we = 1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      cur_max = v;
   endtask

   task automatic send_frame(input logic [7:0] cmd, input bit crc, input logic [7:0] num,
                             input int flaw);
      int          n;
      logic [15:0] c;
      logic [7:0]  s, d;
      n = (cmd == CH_STX) ? 1024 : 128;
      c = '0;
      s = '0;
      rx(cmd);
      rx(num);
      rx((flaw == FLAW_INV) ? ~num ^ 8'h10 : ~num);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: d = 8'h00;
            1: d = 8'hFF;
            default: d = 8'($urandom);
         endcase
         c = u_chk.crc_next(c, d);
         s = s + d;
         rx(d);
         if (flaw == FLAW_SHORT && i == n / 2) begin
            event_only(ACT_TMO);
            return;
         end
      end
      if (flaw == FLAW_CHECK) begin
         c ^= 16'h0100;
         s ^= 8'h01;
      end
      if (crc) begin
         rx(c[15:8]);
         rx(c[7:0]);
      end else begin
         rx(s);
      end
   endtask

   // one transfer: open in CRC or sum mode, one 128-byte frame, then an optional ending
   task automatic transfer(input bit pause_mid);
      bit          crc;
      logic [7:0]  num, pick;
      int          flaw, frames;
      crc = (cur_max < 6 || cur_max > 20) ? 1 : ($urandom_range(0, 2) != 0);
      event_only(ACT_START);
      if (crc) begin
         event_only(ACT_NEXT);
      end else begin
         // let timeouts drain retries until the reply drops from 'C' to NAK
         repeat (int'(cur_max) - int'(cur_max >> 1) + 2) begin
            event_only(ACT_NEXT);
            event_only(ACT_TMO);
         end
         event_only(ACT_NEXT);
      end
      num = 8'h00;
      frames = 1;
      for (int f = 0; f < frames; f++) begin
         flaw = ($urandom_range(0, 9) < 7) ? FLAW_NONE : $urandom_range(FLAW_INV, FLAW_SHORT);
         pick = ($urandom_range(0, 5) == 0) ? num : num + 8'd1;
         if (flaw == FLAW_NUM) pick = num + 8'd2 + 8'($urandom_range(0, 250));
         send_frame(CH_SOH, crc, pick, flaw);
         if (flaw == FLAW_NONE) num = pick;
         if (pause_mid && f == 0) drain();
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
               0: send_item(ACT_READ, 8'($urandom), 10'd0);
               1: send_item(ACT_READ, 8'($urandom), 10'd127);
               2: send_item(ACT_READ, 8'($urandom), 10'd128);
               default: send_item(ACT_READ, 8'($urandom), 10'($urandom));
            endcase
         end
         if ($urandom_range(0, 7) == 0)
            send_item(3'($urandom_range(0, 7)), 8'($urandom), 10'($urandom));
         event_only(ACT_NEXT);
      end
      case ($urandom_range(0, 3))
         0: rx(CH_EOT);
         1: begin
            rx(CH_CAN);
            rx(CH_CAN);
         end
         2: event_only(ACT_TMO);
         default: ;
      endcase
   endtask

   initial begin
      logic [7:0] phase_max[3];
      int         mark;
      reset = 1;
      csr_we = 0;
      csr_wdata = '0;
      req_valid = 0;
      req_action = ACT_START;
      req_rx_byte = '0;
      req_read_index = '0;
      at_end = 0;
      sent_cnt = 0;
      gaps_on = 1;
      stalls_on = 1;
      hold_req = 0;
      cur_max = 8'd10;
      repeat (9) @(negedge clock);
      reset = 0;

      // directed: every event kind and each way a chunk can end
      event_only(ACT_START);
      event_only(ACT_NEXT);          // sends 'C'
      event_only(ACT_TMO);           // chunk ends, no packet
      event_only(ACT_NEXT);
      rx(8'h00);                     // unknown header byte
      event_only(ACT_NEXT);
      rx(CH_CAN);
      rx(8'hFF);                     // lone CAN
      event_only(ACT_NEXT);
      rx(CH_CAN);
      rx(CH_CAN);                    // cancelled, ACK
      for (int k = 1; k <= 3; k++) event_only(ACT_READ + 3'(k));  // ignored codes
      rx(CH_SOH);                    // idle byte, ignored
      event_only(ACT_TMO);           // idle timeout
      send_item(ACT_READ, 8'h00, 10'd1023);
      event_only(ACT_NEXT);
      rx(CH_EOT);                    // end of transfer
      event_only(ACT_NEXT);
      rx(CH_STX);                    // 1K header
      rx(8'h01);
      rx(8'hFE);
      event_only(ACT_TMO);           // timeout mid frame
      set_max_retries(8'd1);
      event_only(ACT_START);
      event_only(ACT_NEXT);
      event_only(ACT_TMO);           // budget gone
      event_only(ACT_NEXT);          // 'C' then CAN CAN CAN
      event_only(ACT_NEXT);          // CAN CAN CAN only

      // random phases at several retry budgets, the largest included
      phase_max = '{8'd10, 8'd255, 8'd8};
      foreach (phase_max[p]) begin
         if (p == 2) begin
            gaps_on = 0;
            stalls_on = 0;
         end
         set_max_retries(phase_max[p]);
         mark = sent_cnt;
         if (p == 1) hold_req = 1;   // long receiver hold while items keep coming
         transfer(p == 0);
         while (sent_cnt - mark < 70) transfer(0);
      end

      drain();
      at_end = 1;
      repeat (3) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
`default_nettype wire
